// ===== hw/rtl/wots_pkg.sv =====
// Package: item types and SHA-256 constants for the WOTS chain verifier.
package wots_pkg;

  localparam logic [1:0] REQ_PK  = 2'd0;
  localparam logic [1:0] REQ_DIG = 2'd1;
  localparam logic [1:0] REQ_SIG = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [8:0]  word_index;
    logic [63:0] word_data;
    logic        last_word;
  } req_t;

  typedef struct packed {
    logic       verify_ok;
    logic [6:0] bad_chain;
  } resp_t;

  // Work handed from front to back: chain check and/or verdict.
  typedef struct packed {
    logic         check;
    logic [7:0]   chain;
    logic [8:0]   steps;
    logic [255:0] value;
    logic         verdict;
  } job_t;

  typedef logic [31:0] word32_t;

  function automatic word32_t k_round(input logic [5:0] i);
    word32_t k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  localparam logic [255:0] H_INIT = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic word32_t rotr(input word32_t x, input int r);
    return (x >> r) | (x << (32 - r));
  endfunction

endpackage

// ===== hw/rtl/wots_front.sv =====
// Front end: store digest and signature words, derive digits, issue chain jobs.
module wots_front import wots_pkg::*; #(
  parameter int CHAIN_COUNT = 67,
  parameter int RADIX = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  req_t in_item,
  output logic in_ready,
  output logic job_valid,
  output job_t job,
  input  logic job_ready
);
  localparam int LG = $clog2(RADIX);
  localparam int NMSG = (256 + LG - 1) / LG;
  localparam int NT = 1 << $clog2(NMSG);
  localparam int SUMW = $clog2(NMSG * (RADIX - 1) + 1) + LG;

  logic [63:0] digest_words [4];
  logic [63:0] chain_buffer [3];
  logic        out_full;

  // Digit of the chain in the incoming signature word, from the stored digest.
  logic [255:0] dig_flat;
  logic [LG-1:0] digit;
  logic [SUMW-1:0] sum, rest;
  logic [7:0] chain;
  logic [8:0] steps;

  assign dig_flat = {digest_words[0], digest_words[1], digest_words[2], digest_words[3]};
  assign chain = 8'(in_item.word_index >> 2);

  // Checksum over the message digits, summed as a balanced adder tree.
  always_comb begin
    logic [NMSG*LG-1:0] padded;
    logic [LG-1:0] d;
    logic [SUMW-1:0] term [NT];
    padded = (NMSG*LG)'({dig_flat, 8'd0} >> (264 - NMSG*LG));
    for (int i = 0; i < NT; i++) term[i] = '0;
    for (int i = 0; i < NMSG; i++) begin
      d = padded[NMSG*LG-1-i*LG -: LG];
      if (int'(d) < RADIX - 1) term[i] = SUMW'(RADIX - 1 - int'(d));
    end
    for (int span = NT >> 1; span > 0; span = span >> 1) begin
      for (int i = 0; i < span; i++) term[i] = term[2*i] + term[2*i+1];
    end
    sum = term[0];
    if (int'(chain) < NMSG) begin
      digit = padded[NMSG*LG-1-int'(chain)*LG -: LG];
      rest = '0;
    end else begin
      rest = sum >> (LG * (int'(chain) - NMSG));
      digit = rest[LG-1:0];
    end
    steps = (int'(digit) < RADIX - 1) ? 9'(RADIX - 1 - int'(digit)) : 9'd0;
  end

  logic is_sig, in_range;
  assign is_sig = in_item.req_type == REQ_SIG;
  assign in_range = int'(in_item.word_index >> 2) < CHAIN_COUNT;
  assign in_ready = !out_full || job_ready;
  assign job_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else begin
      if (job_ready) out_full <= 1'b0;
      if (in_valid && in_ready && is_sig &&
          ((in_range && in_item.word_index[1:0] == 2'd3) || in_item.last_word))
        out_full <= 1'b1;
    end
    if (in_valid && in_ready) begin
      unique case (in_item.req_type)
        REQ_DIG: if (in_item.word_index < 9'd4)
          digest_words[in_item.word_index[1:0]] <= in_item.word_data;
        REQ_SIG: begin
          if (in_range && in_item.word_index[1:0] != 2'd3)
            chain_buffer[in_item.word_index[1:0]] <= in_item.word_data;
          job.check   <= in_range && in_item.word_index[1:0] == 2'd3;
          job.chain   <= chain;
          job.steps   <= steps;
          job.value   <= {chain_buffer[0], chain_buffer[1], chain_buffer[2],
                          in_item.word_data};
          job.verdict <= in_item.last_word;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hw/rtl/wots_back.sv =====
// Back end: iterate SHA-256 over a chain element, compare, give verdict.
module wots_back import wots_pkg::*; #(
  parameter int CHAIN_COUNT = 67
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  job_valid,
  input  job_t  job,
  output logic  job_ready,
  input  logic  pk_we,
  input  logic [8:0] pk_addr,
  input  logic [63:0] pk_data,
  output logic  empty,
  output resp_t result,
  input  logic  pop
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RUN = 3'd1, S_FIN = 3'd2,
                         S_READ = 3'd3, S_CMP = 3'd4, S_OUT = 3'd5;

  logic [63:0] pk_mem [CHAIN_COUNT*4];
  logic [63:0] pk_q;
  logic [8:0]  rd_addr;

  logic [2:0]   state;
  logic [255:0] value;
  logic [8:0]   steps;
  logic [7:0]   chain;
  logic         verdict;
  logic [5:0]   rnd;
  logic [2:0]   wcnt;
  logic         mism, mismatch_seen;
  logic [6:0]   first_bad;
  logic [511:0] w;
  word32_t a, b, c, d, e, f, g, h;

  always_ff @(posedge clk) begin
    if (pk_we) pk_mem[pk_addr] <= pk_data;
    pk_q <= pk_mem[rd_addr];
  end

  word32_t t1, t2, s0, s1, wnew;
  always_comb begin
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + k_round(rnd) + w[511:480];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    s0 = rotr(w[479:448], 7) ^ rotr(w[479:448], 18) ^ (w[479:448] >> 3);
    s1 = rotr(w[63:32], 17) ^ rotr(w[63:32], 19) ^ (w[63:32] >> 10);
    wnew = w[511:480] + s0 + w[223:192] + s1;
    rd_addr = 9'({chain, 2'b00} + {7'd0, wcnt[1:0]});
  end

  assign job_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; empty <= 1'b1; mismatch_seen <= 1'b0;
      first_bad <= 7'(CHAIN_COUNT);
    end else begin
      if (pop && !empty) empty <= 1'b1;
      unique case (state)
        S_IDLE: if (job_valid && job_ready) begin
          value <= job.value; steps <= job.steps; chain <= job.chain;
          verdict <= job.verdict; wcnt <= '0; mism <= 1'b0; rnd <= '0;
          {a, b, c, d, e, f, g, h} <= H_INIT;
          w <= {job.value, 32'h80000000, 192'd0, 32'd256};
          if (!job.check) state <= S_OUT;
          else if (job.steps == 9'd0) state <= S_READ;
          else state <= S_RUN;
        end
        S_RUN: begin
          {a, b, c, d, e, f, g, h} <= {t1 + t2, a, b, c, d + t1, e, f, g};
          w <= {w[479:0], wnew};
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_FIN;
        end
        S_FIN: begin
          value <= {H_INIT[255:224] + a, H_INIT[223:192] + b, H_INIT[191:160] + c,
                    H_INIT[159:128] + d, H_INIT[127:96] + e, H_INIT[95:64] + f,
                    H_INIT[63:32] + g, H_INIT[31:0] + h};
          steps <= steps - 9'd1;
          state <= S_IDLE;
          if (steps == 9'd1) state <= S_READ;
          else begin
            {a, b, c, d, e, f, g, h} <= H_INIT;
            w <= {H_INIT[255:224] + a, H_INIT[223:192] + b, H_INIT[191:160] + c,
                  H_INIT[159:128] + d, H_INIT[127:96] + e, H_INIT[95:64] + f,
                  H_INIT[63:32] + g, H_INIT[31:0] + h, 32'h80000000, 192'd0, 32'd256};
            state <= S_RUN;
          end
        end
        S_READ: begin
          wcnt <= 3'd1; state <= S_CMP;
        end
        S_CMP: begin
          if (pk_q != value[255:192]) mism <= 1'b1;
          value <= {value[191:0], 64'd0};
          wcnt <= wcnt + 3'd1;
          if (wcnt == 3'd4) begin
            if (mism || pk_q != value[255:192]) begin
              mismatch_seen <= 1'b1;
              if (7'(chain) < first_bad) first_bad <= 7'(chain);
            end
            state <= S_OUT;
          end
        end
        default: begin
          // Hold a verdict here until the result register is free.
          if (!verdict) begin
            state <= S_IDLE;
          end else if (empty || pop) begin
            result.verify_ok <= !mismatch_seen;
            result.bad_chain <= first_bad;
            empty <= 1'b0;
            mismatch_seen <= 1'b0;
            first_bad <= 7'(CHAIN_COUNT);
            state <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule

// ===== hw/rtl/wots_chain_verifier_core.sv =====
// Top level: WOTS (w = 16) chain verifier over SHA-256.
//
//  channel  | handshake     | payload
//  ---------+---------------+-------------------------------------------
//  request  | push / full   | req_t  : req_type, word_index, word_data, last_word
//  verdict  | pop / empty   | resp_t : verify_ok, bad_chain
//
// Flow: a SHA-256 compression is 64 rounds of the single round unit plus finish;
// a chain check holds the back end for steps compressions, then the key read and
// compare; a verdict-only item skips to output. The round unit sets the rate.
// Reset: rst clears the control state; the key store is undefined until written.
// Stalls: a one-entry job register parts front and back; key words wait until
// the back end is idle; a verdict waits in the back end while one is unpopped.
module wots_chain_verifier_core import wots_pkg::*; #(
  parameter int CHAIN_COUNT = 67,
  parameter int RADIX = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  req_t  req,
  output logic  full,
  output logic  empty,
  output resp_t resp,
  input  logic  pop
);
  logic job_valid, job_ready, in_ready, pk_we, pk_block;
  job_t job;

  // Hold key words off while a chain check may still read the store.
  assign pk_block = req.req_type == REQ_PK && (job_valid || !job_ready);
  assign full = !in_ready || pk_block;
  // Write key words straight to the back end's store.
  assign pk_we = push && !full && req.req_type == REQ_PK &&
                 int'(req.word_index) < CHAIN_COUNT * 4;

  wots_front #(.CHAIN_COUNT(CHAIN_COUNT), .RADIX(RADIX)) u_front (
    .clk, .rst, .in_valid(push), .in_item(req), .in_ready,
    .job_valid, .job, .job_ready
  );

  wots_back #(.CHAIN_COUNT(CHAIN_COUNT)) u_back (
    .clk, .rst, .job_valid, .job, .job_ready,
    .pk_we, .pk_addr(req.word_index), .pk_data(req.word_data),
    .empty, .result(resp), .pop
  );
endmodule

// ===== bench/wots_chain_verifier_core_tb.sv =====
// Testbench for the WOTS chain verifier: signature sessions and noise against a verdict predictor.
`timescale 1ns / 1ps

module wots_chain_verifier_core_tb;
  import wots_pkg::*;

  localparam int          CHAINS      = 67;
  localparam int          KEY_WORDS   = CHAINS * 4;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int          STALL_LIMIT = 20000;
  localparam int          DRAIN_WAIT  = 2100;
  localparam int          HOLD_CYCLES = 3000;

  // Predicts verdicts from accepted items and checks them as they come out.
  class wots_verdict_board;
    logic [63:0] key_words [KEY_WORDS];
    logic [63:0] digest [4];
    logic [3:0]  digit [CHAINS];
    logic [63:0] sig_words [4];
    bit          any_bad;
    logic [6:0]  lowest_bad;
    resp_t       verdict_q [$];
    int          errors;
    int          verdicts_checked;
    int          passes_expected;
    int          fails_expected;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      foreach (digest[i]) digest[i] = '0;
      foreach (sig_words[i]) sig_words[i] = '0;
      foreach (digit[i]) digit[i] = '0;
      any_bad = 1'b0;
      lowest_bad = 7'(CHAINS);
      errors = 0;
      verdicts_checked = 0;
      passes_expected = 0;
      fails_expected = 0;
    endfunction

    static function logic [31:0] ror32(logic [31:0] x, int r);
      return (x >> r) | (x << (32 - r));
    endfunction

    // One SHA-256 of a 32-byte value, first byte in the top bits.
    static function logic [255:0] sha_once(logic [255:0] v);
      logic [31:0] kt [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      logic [31:0] iv [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      logic [31:0] m [64];
      logic [31:0] s [8];
      logic [31:0] t1, t2, s0, s1;
      logic [255:0] res;
      for (int i = 0; i < 8; i++) m[i] = v[255 - 32 * i -: 32];
      m[8] = 32'h80000000;
      for (int i = 9; i < 15; i++) m[i] = '0;
      m[15] = 32'd256;
      for (int i = 16; i < 64; i++) begin
        s0 = ror32(m[i-15], 7) ^ ror32(m[i-15], 18) ^ (m[i-15] >> 3);
        s1 = ror32(m[i-2], 17) ^ ror32(m[i-2], 19) ^ (m[i-2] >> 10);
        m[i] = m[i-16] + s0 + m[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) s[i] = iv[i];
      for (int i = 0; i < 64; i++) begin
        t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25))
           + ((s[4] & s[5]) ^ (~s[4] & s[6])) + kt[i] + m[i];
        t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22))
           + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
        s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
        s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) res[255 - 32 * i -: 32] = s[i] + iv[i];
      return res;
    endfunction

    static function logic [255:0] walk_chain(logic [255:0] v, int steps);
      logic [255:0] r;
      r = v;
      for (int i = 0; i < steps; i++) r = sha_once(r);
      return r;
    endfunction

    // Message digits MSB first, then the checksum, least significant digit first.
    function void refresh_digits();
      logic [255:0] d;
      logic [11:0]  sum;
      d = {digest[0], digest[1], digest[2], digest[3]};
      sum = '0;
      for (int i = 0; i < 64; i++) begin
        digit[i] = d[255 - 4 * i -: 4];
        sum += 12'(15 - digit[i]);
      end
      digit[64] = sum[3:0];
      digit[65] = sum[7:4];
      digit[66] = sum[11:8];
    endfunction

    function void note_request(req_t r);
      int ch;
      resp_t v;
      ch = int'(r.word_index) >> 2;
      case (r.req_type)
        REQ_PK: begin
          if (r.word_index < KEY_WORDS) key_words[r.word_index] = r.word_data;
        end
        REQ_DIG: begin
          if (r.word_index < 4) begin
            digest[r.word_index] = r.word_data;
            refresh_digits();
          end
        end
        REQ_SIG: begin
          if (ch < CHAINS) begin
            sig_words[r.word_index[1:0]] = r.word_data;
            if (r.word_index[1:0] == 2'd3 &&
                walk_chain({sig_words[0], sig_words[1], sig_words[2], sig_words[3]},
                           15 - digit[ch]) !=
                {key_words[ch*4], key_words[ch*4+1], key_words[ch*4+2], key_words[ch*4+3]})
            begin
              any_bad = 1'b1;
              if (7'(ch) < lowest_bad) lowest_bad = 7'(ch);
            end
          end
          if (r.last_word) begin
            v.verify_ok = !any_bad;
            v.bad_chain = lowest_bad;
            verdict_q.push_back(v);
            if (any_bad) fails_expected++;
            else passes_expected++;
            any_bad = 1'b0;
            lowest_bad = 7'(CHAINS);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(resp_t got);
      resp_t want;
      verdicts_checked++;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("verdict ok=%0d bad=%0d arrived with none expected",
                   got.verify_ok, got.bad_chain);
        return;
      end
      want = verdict_q.pop_front();
      if (got.verify_ok !== want.verify_ok || got.bad_chain !== want.bad_chain) begin
        errors++;
        if (errors <= 10)
          $display("verdict %0d: expected ok=%0d bad=%0d, got ok=%0d bad=%0d",
                   verdicts_checked, want.verify_ok, want.bad_chain,
                   got.verify_ok, got.bad_chain);
      end
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  push;
  req_t  req;
  logic  full;
  logic  empty;
  resp_t resp;
  logic  pop;

  wots_chain_verifier_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .req   (req),
    .full  (full),
    .empty (empty),
    .resp  (resp),
    .pop   (pop)
  );

  wots_verdict_board board = new();

  // Which stores have been written since reset: never read an unwritten entry.
  bit       key_written [KEY_WORDS];
  bit [3:0] digest_written;
  bit [3:0] sig_written;

  int  items_sent;
  int  sessions_run;
  int  noise_sent;
  bit  sender_eager;   // no gaps between items while set
  int  stall_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: give up when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [255:0] rand256();
    return {rand64(), rand64(), rand64(), rand64()};
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input req_t r);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    req  <= r;
    do @(posedge clk); while (full);
    board.note_request(r);
    items_sent++;
    case (r.req_type)
      REQ_PK:  if (r.word_index < KEY_WORDS) key_written[r.word_index] = 1'b1;
      REQ_DIG: if (r.word_index < 4) digest_written[r.word_index] = 1'b1;
      REQ_SIG: if (r.word_index < KEY_WORDS) sig_written[r.word_index[1:0]] = 1'b1;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_word(input logic [1:0] kind, input int idx, input logic [63:0] data,
                           input bit last);
    req_t r;
    r.req_type   = kind;
    r.word_index = 9'(idx);
    r.word_data  = data;
    r.last_word  = last;
    send_item(r);
  endtask

  task automatic send_digest(input logic [255:0] d);
    for (int w = 0; w < 4; w++) send_word(REQ_DIG, w, d[255 - 64 * w -: 64], 1'b0);
  endtask

  // Write a chain's key as the walked signature element (spoiled on request), then sign.
  task automatic send_chain(input int ch, input logic [255:0] sig, input bit spoil,
                            input bit last);
    logic [255:0] key;
    key = wots_verdict_board::walk_chain(sig, 15 - board.digit[ch]);
    if (spoil) key ^= 256'b1 << $urandom_range(0, 255);
    for (int w = 0; w < 4; w++) send_word(REQ_PK, ch * 4 + w, key[255 - 64 * w -: 64], 1'b0);
    for (int w = 0; w < 4; w++)
      send_word(REQ_SIG, ch * 4 + w, sig[255 - 64 * w -: 64], last && w == 3);
  endtask

  function automatic logic [255:0] pick_digest();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return rand256();
    endcase
  endfunction

  // A well-formed session: fresh digest now and then, a few chains, one verdict.
  task automatic run_session();
    int n;
    int ch;
    sessions_run++;
    sender_eager = ($urandom_range(0, 3) == 0);
    if (digest_written != 4'hf || $urandom_range(0, 9) < 7) send_digest(pick_digest());
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      ch = ($urandom_range(0, 9) < 3) ? $urandom_range(64, CHAINS - 1)
                                      : $urandom_range(0, CHAINS - 1);
      send_chain(ch, rand256(), $urandom_range(0, 9) < 3, i == n - 1);
    end
  endtask

  // Out-of-range, unused and stray items, plus lone signature words.
  task automatic send_noise();
    int ch;
    noise_sent++;
    case ($urandom_range(0, 7))
      0: send_word(REQ_UNUSED, $urandom_range(0, 511), rand64(), $urandom_range(0, 1));
      1: send_word(REQ_PK, $urandom_range(KEY_WORDS, 511), rand64(), $urandom_range(0, 1));
      2: send_word(REQ_DIG, $urandom_range(4, 511), rand64(), $urandom_range(0, 1));
      3: send_word(REQ_SIG, $urandom_range(KEY_WORDS, 511), rand64(), $urandom_range(0, 1));
      4: send_word(REQ_PK, $urandom_range(0, KEY_WORDS - 1), rand64(), 1'b0);
      5: send_word(REQ_SIG, $urandom_range(0, CHAINS - 1) * 4 + $urandom_range(0, 2),
                   rand64(), $urandom_range(0, 1));
      6: begin
        // Complete a chain only where every word it reads has been written.
        ch = $urandom_range(0, CHAINS - 1);
        if (digest_written == 4'hf && sig_written[2:0] == 3'h7 && key_written[ch*4] &&
            key_written[ch*4+1] && key_written[ch*4+2] && key_written[ch*4+3])
          send_word(REQ_SIG, ch * 4 + 3, rand64(), $urandom_range(0, 1));
        else
          send_word(REQ_SIG, ch * 4, rand64(), 1'b0);
      end
      default: begin
        if (digest_written == 4'hf)
          send_word(REQ_DIG, $urandom_range(0, 3), rand64(), $urandom_range(0, 1));
        else
          send_word(REQ_UNUSED, 0, '0, 1'b1);
      end
    endcase
  endtask

  // Result side: random pops, one long hold-off so the block backs up.
  initial begin
    bit held;
    int gap;
    held = 1'b0;
    pop  = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst) begin
        if (!held && board.verdicts_checked >= 3) begin
          held = 1'b1;
          pop <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        pop <= 1'b1;
        do @(posedge clk); while (empty);
        board.check_verdict(resp);
      end
    end
  end

  initial begin
    rst  = 1'b1;
    push = 1'b0;
    req  = '0;
    items_sent = 0;
    sessions_run = 0;
    noise_sent = 0;
    sender_eager = 1'b0;
    digest_written = '0;
    sig_written = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: stray items before anything is written.
    send_word(REQ_UNUSED, 511, '1, 1'b1);
    send_word(REQ_PK, 0, '1, 1'b1);                      // last flag ignored off signatures
    send_word(REQ_SIG, 511, '0, 1'b1);                   // out of range, verdict still given
    // All-ones digest: message chains need no hashing, checksum chains the full walk.
    send_digest('1);
    send_chain(0, '1, 1'b0, 1'b0);
    send_chain(CHAINS - 1, '0, 1'b0, 1'b1);
    // All-zero digest: every message chain walks fifteen steps; spoil a checksum chain.
    send_digest('0);
    send_chain(CHAINS - 2, rand256(), 1'b1, 1'b1);

    // Random: mostly well-formed sessions, the rest noise.
    while (items_sent < 1250) begin
      if ($urandom_range(0, 3) != 0) begin
        run_session();
      end else begin
        sender_eager = 1'b0;
        repeat ($urandom_range(1, 3)) send_noise();
      end
    end
    push <= 1'b0;

    while (board.verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d items: %0d sessions, %0d noise items.",
             items_sent, sessions_run, noise_sent);
    $display("Checked %0d verdicts (%0d pass, %0d fail expected).",
             board.verdicts_checked, board.passes_expected, board.fails_expected);
    if (board.errors == 0 && board.verdict_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
